@@ hw/rtl/rle_pkg.sv @@
package rle_pkg;

    localparam int MaxLiteralsDefault = 16;
    localparam int MaxRun = 255;
    // longest repeat token, bounded by the 8-bit count field
    localparam int RunCap = (MaxRun < 255) ? MaxRun : 255;
    localparam int CmdQDepth = 4;

    localparam logic [1:0] TOK_REPEAT   = 2'd0;
    localparam logic [1:0] TOK_LIT_HDR  = 2'd1;
    localparam logic [1:0] TOK_LIT_BYTE = 2'd2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       stream_end;
    } t_in_item;

    typedef struct packed {
        logic [1:0] token_kind;
        logic [7:0] run_count;
        logic [7:0] token_byte;
        logic       last_of_item;
        logic       last_of_stream;
    } t_out_item;

    typedef enum logic [1:0] {
        CMD_HOLD,
        CMD_SEND,
        CMD_REPEAT
    } t_cmd_op;

    typedef struct packed {
        t_cmd_op    op;
        logic [7:0] count;
        logic [7:0] value;
        logic       last_item;
        logic       last_stream;
    } t_cmd;

    typedef enum logic {
        BK_IDLE,
        BK_BYTES
    } t_back_state;

endpackage

@@ hw/rtl/rle_front.sv @@
module rle_front
    import rle_pkg::*;
#(
    parameter int MAX_LITERALS = MaxLiteralsDefault
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_in_item i_item,
    output logic     o_full,
    output logic     o_cmd_push,
    output t_cmd     o_cmd,
    input  logic     i_cmd_full
);

    localparam int LCW = $clog2(MAX_LITERALS);
    localparam int LitCap = MAX_LITERALS - 1;
    localparam int NumSlots = 7;

    // command slots, issued in this order
    localparam int SL_SEND_EARLY = 0;
    localparam int SL_REP1       = 1;
    localparam int SL_HOLD1      = 2;
    localparam int SL_SEND1      = 3;
    localparam int SL_REP_END    = 4;
    localparam int SL_HOLD_END   = 5;
    localparam int SL_SEND_END   = 6;

    logic [7:0]          r_prev, n_prev;
    logic                r_have, n_have;
    logic [7:0]          r_rc, n_rc;
    logic [LCW-1:0]      r_lc, n_lc;
    logic [NumSlots-1:0] r_mask, n_mask, plan, low_bit, rest;
    logic                r_end;
    logic [7:0]          r_rep1_cnt, r_rep1_val, r_hold1_val;
    logic [7:0]          r_rep_end_cnt, r_rep_end_val, r_hold_end_val;
    logic [7:0]          p_rep1_cnt, p_rep1_val, p_hold1_val;
    logic [7:0]          p_rep_end_cnt, p_rep_end_val, p_hold_end_val;
    logic [7:0]          rc_inc;
    logic [LCW-1:0]      lc_inc;
    logic                accept, issue, last_cmd;

    assign low_bit  = r_mask & (~r_mask + NumSlots'(1));
    assign rest     = r_mask & ~low_bit;
    assign last_cmd = (r_mask != '0) && (rest == '0);
    assign issue    = (r_mask != '0) && !i_cmd_full;
    assign o_full   = !((r_mask == '0) || (last_cmd && !i_cmd_full));
    assign accept   = i_push && !o_full;
    assign rc_inc   = r_rc + 8'd1;
    assign lc_inc   = r_lc + LCW'(1);

    // classify the byte against the pending one and plan the commands
    always_comb begin
        n_prev         = r_prev;
        n_have         = r_have;
        n_rc           = r_rc;
        n_lc           = r_lc;
        plan           = '0;
        p_rep1_cnt     = '0;
        p_rep1_val     = '0;
        p_hold1_val    = '0;
        p_rep_end_cnt  = '0;
        p_rep_end_val  = '0;
        p_hold_end_val = '0;
        if (!r_have) begin
            n_prev = i_item.data_byte;
            n_rc   = 8'd1;
            n_have = 1'b1;
        end else if (i_item.data_byte == r_prev) begin
            // a run starts: literals held so far go out first
            if (r_rc == 8'd1 && r_lc != '0) begin
                plan[SL_SEND_EARLY] = 1'b1;
                n_lc = '0;
            end
            if (int'(rc_inc) >= RunCap) begin
                plan[SL_REP1] = 1'b1;
                p_rep1_cnt    = rc_inc;
                p_rep1_val    = i_item.data_byte;
                n_have        = 1'b0;
                n_rc          = 8'd1;
            end else begin
                n_rc = rc_inc;
            end
        end else begin
            if (r_rc >= 8'd2) begin
                plan[SL_REP1] = 1'b1;
                p_rep1_cnt    = r_rc;
                p_rep1_val    = r_prev;
            end else begin
                plan[SL_HOLD1] = 1'b1;
                p_hold1_val    = r_prev;
                if (int'(lc_inc) >= LitCap) begin
                    plan[SL_SEND1] = 1'b1;
                    n_lc = '0;
                end else begin
                    n_lc = lc_inc;
                end
            end
            n_prev = i_item.data_byte;
            n_rc   = 8'd1;
        end
        if (i_item.stream_end) begin
            if (n_have) begin
                if (n_rc >= 8'd2) begin
                    plan[SL_REP_END] = 1'b1;
                    p_rep_end_cnt    = n_rc;
                    p_rep_end_val    = n_prev;
                end else begin
                    plan[SL_HOLD_END] = 1'b1;
                    plan[SL_SEND_END] = 1'b1;
                    p_hold_end_val    = n_prev;
                end
            end
            n_prev = '0;
            n_have = 1'b0;
            n_rc   = 8'd1;
            n_lc   = '0;
        end
    end

    always_comb begin
        n_mask = r_mask;
        if (issue) begin
            n_mask = rest;
        end
        if (accept) begin
            n_mask = plan;
        end
    end

    // lowest pending slot goes to the queue
    always_comb begin
        o_cmd = '0;
        if (r_mask[SL_SEND_EARLY]) begin
            o_cmd.op = CMD_SEND;
        end else if (r_mask[SL_REP1]) begin
            o_cmd.op    = CMD_REPEAT;
            o_cmd.count = r_rep1_cnt;
            o_cmd.value = r_rep1_val;
        end else if (r_mask[SL_HOLD1]) begin
            o_cmd.op    = CMD_HOLD;
            o_cmd.value = r_hold1_val;
        end else if (r_mask[SL_SEND1]) begin
            o_cmd.op = CMD_SEND;
        end else if (r_mask[SL_REP_END]) begin
            o_cmd.op    = CMD_REPEAT;
            o_cmd.count = r_rep_end_cnt;
            o_cmd.value = r_rep_end_val;
        end else if (r_mask[SL_HOLD_END]) begin
            o_cmd.op    = CMD_HOLD;
            o_cmd.value = r_hold_end_val;
        end else begin
            o_cmd.op = CMD_SEND;
        end
        o_cmd.last_item   = last_cmd;
        o_cmd.last_stream = last_cmd && r_end;
    end

    assign o_cmd_push = issue;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= '0;
            r_have <= 1'b0;
            r_rc   <= 8'd1;
            r_lc   <= '0;
            r_mask <= '0;
            r_end  <= 1'b0;
        end else begin
            r_mask <= n_mask;
            if (accept) begin
                r_prev <= n_prev;
                r_have <= n_have;
                r_rc   <= n_rc;
                r_lc   <= n_lc;
                r_end  <= i_item.stream_end;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rep1_cnt     <= p_rep1_cnt;
            r_rep1_val     <= p_rep1_val;
            r_hold1_val    <= p_hold1_val;
            r_rep_end_cnt  <= p_rep_end_cnt;
            r_rep_end_val  <= p_rep_end_val;
            r_hold_end_val <= p_hold_end_val;
        end
    end

    a_lc_below_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_lc) < LitCap)
        else $error("front literal count reached the group limit");

    a_rc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rc != 8'd0 && int'(r_rc) < RunCap)
        else $error("front repeat count out of range");

    a_idle_rc_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_have |-> r_rc == 8'd1)
        else $error("repeat count not one without a pending byte");

endmodule

@@ hw/rtl/rle_cmd_fifo.sv @@
module rle_cmd_fifo
    import rle_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output t_cmd o_cmd,
    output logic o_empty
);

    localparam int QAW = $clog2(CmdQDepth);

    t_cmd           r_q [CmdQDepth];
    logic [QAW-1:0] r_wr_ptr, r_rd_ptr;
    logic [QAW:0]   r_count;
    logic           do_push, do_pop;

    assign o_full  = (r_count == (QAW+1)'(CmdQDepth));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_cmd   = r_q[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + QAW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + QAW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + (QAW+1)'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - (QAW+1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_q[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

@@ hw/rtl/rle_back.sv @@
module rle_back
    import rle_pkg::*;
#(
    parameter int MAX_LITERALS = MaxLiteralsDefault
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cmd      i_cmd,
    input  logic      i_cmd_empty,
    output logic      o_cmd_pop,
    output t_out_item o_token,
    output logic      o_empty,
    input  logic      i_pop
);

    localparam int LCW = $clog2(MAX_LITERALS);
    localparam int LitCap = MAX_LITERALS - 1;

    t_back_state    r_state, n_state;
    logic [LCW-1:0] r_cnt, n_cnt;
    logic [LCW-1:0] r_idx, n_idx;
    logic [7:0]     r_lit [MAX_LITERALS];
    logic [7:0]     r_rd;
    logic           r_ov, n_ov;
    t_out_item      r_out, n_out;
    logic           r_flag_item, r_flag_stream;
    logic           out_free, last_byte, lit_we;

    assign out_free  = !r_ov || i_pop;
    assign last_byte = (r_idx == r_cnt - LCW'(1));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_IDLE: begin
                if (o_cmd_pop && i_cmd.op == CMD_SEND) begin
                    n_state = BK_BYTES;
                end
            end
            BK_BYTES: begin
                if (out_free && last_byte) begin
                    n_state = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    always_comb begin
        o_cmd_pop = 1'b0;
        lit_we    = 1'b0;
        n_cnt     = r_cnt;
        n_idx     = r_idx;
        n_ov      = r_ov && !i_pop;
        n_out     = r_out;
        unique case (r_state)
            BK_IDLE: begin
                if (!i_cmd_empty) begin
                    unique case (i_cmd.op)
                        CMD_HOLD: begin
                            o_cmd_pop = 1'b1;
                            lit_we    = 1'b1;
                            n_cnt     = r_cnt + LCW'(1);
                        end
                        CMD_REPEAT: begin
                            if (out_free) begin
                                o_cmd_pop            = 1'b1;
                                n_ov                 = 1'b1;
                                n_out.token_kind     = TOK_REPEAT;
                                n_out.run_count      = i_cmd.count;
                                n_out.token_byte     = i_cmd.value;
                                n_out.last_of_item   = i_cmd.last_item;
                                n_out.last_of_stream = i_cmd.last_stream;
                            end
                        end
                        CMD_SEND: begin
                            // header now, held bytes follow from the store
                            if (out_free) begin
                                o_cmd_pop            = 1'b1;
                                n_ov                 = 1'b1;
                                n_idx                = '0;
                                n_out.token_kind     = TOK_LIT_HDR;
                                n_out.run_count      = 8'(r_cnt);
                                n_out.token_byte     = '0;
                                n_out.last_of_item   = 1'b0;
                                n_out.last_of_stream = 1'b0;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            BK_BYTES: begin
                if (out_free) begin
                    n_ov                 = 1'b1;
                    n_out.token_kind     = TOK_LIT_BYTE;
                    n_out.run_count      = '0;
                    n_out.token_byte     = r_rd;
                    n_out.last_of_item   = last_byte && r_flag_item;
                    n_out.last_of_stream = last_byte && r_flag_stream;
                    n_idx                = r_idx + LCW'(1);
                    if (last_byte) begin
                        n_cnt = '0;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
            r_cnt   <= '0;
            r_idx   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_idx   <= n_idx;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (o_cmd_pop && i_cmd.op == CMD_SEND) begin
            r_flag_item   <= i_cmd.last_item;
            r_flag_stream <= i_cmd.last_stream;
        end
    end

    // literal store: read data always tracks the next byte index
    always_ff @(posedge i_clk) begin
        if (lit_we) begin
            r_lit[r_cnt] <= i_cmd.value;
        end
        r_rd <= r_lit[n_idx];
    end

    assign o_token = r_out;
    assign o_empty = !r_ov;

    a_cnt_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_cnt) <= LitCap)
        else $error("literal store over its group limit");

    a_bytes_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == BK_BYTES |-> r_cnt != '0)
        else $error("sending literal bytes from an empty store");

    a_send_has_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd_pop && i_cmd.op == CMD_SEND) |-> r_cnt != '0)
        else $error("literal group request with no held bytes");

endmodule

@@ hw/rtl/run_length_encoder.sv @@
// Run-length encoder with literal groups. Bytes go in on a push/full queue
// port, tokens come out on an empty/pop queue port: repeat tokens (count and
// byte), literal headers (count) and literal bytes. A byte is judged one
// request late, once the next byte shows whether it starts a run; a byte
// marked as stream end flushes everything and always gives at least one
// token. The front classifier takes one byte per cycle while at most one
// planned command is pending and, if one is, the queue has room; it issues
// the commands it plans (hold, send group, repeat; none to four per byte)
// one per cycle, stalling while the four-deep command queue is full. The
// back end writes hold commands into a small store with a registered read
// port and turns the others into repeat tokens or literal headers and bytes.
// MAX_LITERALS sets the store depth; a literal group is sent once it holds
// MAX_LITERALS - 1 bytes.
module run_length_encoder
    import rle_pkg::*;
#(
    parameter int MAX_LITERALS = MaxLiteralsDefault
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      push,
    input  t_in_item  i_item,
    output logic      full,
    input  logic      pop,
    output t_out_item o_token,
    output logic      empty
);

    t_cmd fr_cmd, q_cmd;
    logic fr_push, q_full, q_empty, q_pop;

    rle_front #(
        .MAX_LITERALS(MAX_LITERALS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_item     (i_item),
        .o_full     (full),
        .o_cmd_push (fr_push),
        .o_cmd      (fr_cmd),
        .i_cmd_full (q_full)
    );

    rle_cmd_fifo u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fr_push),
        .i_cmd   (fr_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_cmd   (q_cmd),
        .o_empty (q_empty)
    );

    rle_back #(
        .MAX_LITERALS(MAX_LITERALS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (q_cmd),
        .i_cmd_empty (q_empty),
        .o_cmd_pop   (q_pop),
        .o_token     (o_token),
        .o_empty     (empty),
        .i_pop       (pop)
    );

endmodule
